FILE: sv/vic_pkg.sv
// Package for the variable index compactor.
// Sizes, command/kind/status codes, the query token type and controller states.
// No dependencies.
package vic_pkg;

  localparam int MAX_VARS   = 256;
  localparam int INDEX_BITS = 32;
  localparam int POS_W      = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int CNT_W      = $clog2(MAX_VARS + 1);

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FWD   = 2'd1;
  localparam logic [1:0] CMD_REV   = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ALG  = 2'd1;
  localparam logic [1:0] KIND_DIF  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Query that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic                  active;
    logic                  rev;
    logic [1:0]            kind;
    logic [INDEX_BITS-1:0] idx;
    logic [CNT_W-1:0]      count;
    logic                  found;
    logic                  appended;
    logic [1:0]            res_kind;
    logic [31:0]           res_index;
  } token_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_FINISH
  } state_t;

endpackage

FILE: sv/vic_cell.sv
// One cell of the entry row: holds one table entry and matches the passing token.
// Depends on vic_pkg.
module vic_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [vic_pkg::POS_W-1:0] pos,
  input  vic_pkg::token_t        tok_in,
  output vic_pkg::token_t        tok_out
);

  logic                           ent_dif;
  logic [vic_pkg::INDEX_BITS-1:0] ent_orig;
  vic_pkg::token_t                tok_next;
  logic                           wr;
  logic                           in_use;
  logic                           tok_dif;

  always_comb begin
    tok_next = tok_in;
    wr       = 1'b0;
    in_use   = vic_pkg::CNT_W'(pos) < tok_in.count;
    tok_dif  = (tok_in.kind == vic_pkg::KIND_DIF);
    if (tok_in.active && !tok_in.found) begin
      if (!tok_in.rev) begin
        if (in_use && ent_dif == tok_dif && ent_orig == tok_in.idx) begin
          tok_next.found     = 1'b1;
          tok_next.res_kind  = vic_pkg::KIND_ALG;
          tok_next.res_index = 32'(pos);
        end else if (vic_pkg::CNT_W'(pos) == tok_in.count) begin
          // First free slot and no earlier match: this cell takes the new entry.
          wr                 = 1'b1;
          tok_next.found     = 1'b1;
          tok_next.appended  = 1'b1;
          tok_next.res_kind  = vic_pkg::KIND_ALG;
          tok_next.res_index = 32'(pos);
        end
      end else if (in_use && 32'(tok_in.idx) == 32'(pos)) begin
        tok_next.found     = 1'b1;
        tok_next.res_kind  = ent_dif ? vic_pkg::KIND_DIF : vic_pkg::KIND_ALG;
        tok_next.res_index = 32'(ent_orig);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      ent_dif  <= tok_dif;
      ent_orig <= tok_in.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

FILE: sv/vic_ctrl.sv
// Controller: input and output handshakes, counters, token injection and collection.
// Depends on vic_pkg.
module vic_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             command,
  input  logic [1:0]             ref_kind,
  input  logic [31:0]            var_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_kind,
  output logic [31:0]            out_index,
  output logic [8:0]             alg_count,
  output logic [8:0]             dif_count,
  output logic [1:0]             status,
  output vic_pkg::token_t        inj,
  input  vic_pkg::token_t        ret
);

  vic_pkg::state_t         state, state_next;
  logic [vic_pkg::CNT_W-1:0] entry_count, entry_count_next;
  logic [vic_pkg::CNT_W-1:0] alg_cnt, alg_cnt_next;
  logic [vic_pkg::CNT_W-1:0] dif_cnt, dif_cnt_next;
  vic_pkg::token_t         hold, hold_next;
  logic                    out_valid_next;
  logic [1:0]              out_kind_next;
  logic [31:0]             out_index_next;
  logic [1:0]              status_next;
  logic                    out_free;
  logic                    accept;
  logic                    to_chain;
  logic [vic_pkg::INDEX_BITS-1:0] idx_m;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != vic_pkg::S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign idx_m     = var_index[vic_pkg::INDEX_BITS-1:0];
  assign to_chain  = (command == vic_pkg::CMD_FWD &&
                      (ref_kind == vic_pkg::KIND_ALG || ref_kind == vic_pkg::KIND_DIF)) ||
                     (command == vic_pkg::CMD_REV && ref_kind == vic_pkg::KIND_ALG);
  assign alg_count = 9'(alg_cnt);
  assign dif_count = 9'(dif_cnt);

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    alg_cnt_next     = alg_cnt;
    dif_cnt_next     = dif_cnt;
    hold_next        = hold;
    out_valid_next   = out_valid && out_stall;
    out_kind_next    = out_kind;
    out_index_next   = out_index;
    status_next      = status;

    inj           = '0;
    inj.rev       = (command == vic_pkg::CMD_REV);
    inj.kind      = ref_kind;
    inj.idx       = idx_m;
    inj.count     = entry_count;
    inj.active    = accept && to_chain;

    case (state)
      vic_pkg::S_IDLE: begin
        if (accept) begin
          if (to_chain) begin
            state_next = vic_pkg::S_BUSY;
          end else if (command == vic_pkg::CMD_START) begin
            entry_count_next = '0;
            alg_cnt_next     = '0;
            dif_cnt_next     = '0;
            out_valid_next   = 1'b1;
            out_kind_next    = vic_pkg::KIND_NONE;
            out_index_next   = '0;
            status_next      = vic_pkg::ST_OK;
          end else begin
            out_valid_next = 1'b1;
            out_kind_next  = ref_kind;
            out_index_next = 32'(idx_m);
            status_next    = vic_pkg::ST_OK;
          end
        end
      end
      vic_pkg::S_BUSY: begin
        if (ret.active) begin
          hold_next  = ret;
          state_next = vic_pkg::S_FINISH;
        end
      end
      vic_pkg::S_FINISH: begin
        if (out_free) begin
          state_next     = vic_pkg::S_IDLE;
          out_valid_next = 1'b1;
          if (hold.found) begin
            out_kind_next  = hold.res_kind;
            out_index_next = hold.res_index;
            status_next    = vic_pkg::ST_OK;
          end else begin
            out_kind_next  = hold.kind;
            out_index_next = 32'(hold.idx);
            status_next    = hold.rev ? vic_pkg::ST_RANGE : vic_pkg::ST_FULL;
          end
          if (hold.appended) begin
            entry_count_next = entry_count + 1'b1;
            if (hold.kind == vic_pkg::KIND_DIF) begin
              dif_cnt_next = dif_cnt + 1'b1;
            end else begin
              alg_cnt_next = alg_cnt + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = vic_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= vic_pkg::S_IDLE;
      entry_count <= '0;
      alg_cnt     <= '0;
      dif_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      alg_cnt     <= alg_cnt_next;
      dif_cnt     <= dif_cnt_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold      <= hold_next;
    out_kind  <= out_kind_next;
    out_index <= out_index_next;
    status    <= status_next;
  end

endmodule

FILE: sv/variable_index_compactor_top.sv
// A start, pass-through or unused-command item gives its result in the cycle after
// acceptance, so such items flow at one per cycle while the output is not stalled.
// Forward and reverse renames pass the row, then the hold register, then the output registers:
// the query walks the row of MAX_VARS entry cells one cell per cycle, one item at a time.
// Reset (synchronous, rst high) clears the counts and the row's tokens; entry contents
// stay undefined and are never read before they are written.
module variable_index_compactor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [1:0]  ref_kind,
  input  logic [31:0] var_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_index,
  output logic [8:0]  alg_count,
  output logic [8:0]  dif_count,
  output logic [1:0]  status
);

  vic_pkg::token_t              link [vic_pkg::MAX_VARS+1];
  logic [vic_pkg::MAX_VARS:0]   act_vec;
  logic [8:0]                   cnt_sum;

  vic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .ref_kind  (ref_kind),
    .var_index (var_index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_index (out_index),
    .alg_count (alg_count),
    .dif_count (dif_count),
    .status    (status),
    .inj       (link[0]),
    .ret       (link[vic_pkg::MAX_VARS])
  );

  for (genvar i = 0; i < vic_pkg::MAX_VARS; i++) begin : g_cell
    vic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .pos     (vic_pkg::POS_W'(i)),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  for (genvar i = 0; i <= vic_pkg::MAX_VARS; i++) begin : g_act
    assign act_vec[i] = link[i].active;
  end

  assign cnt_sum = alg_count + dif_count;

`ifndef ASSERT_OFF
  // Only one query is ever in flight along the row.
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(act_vec))
    else $error("more than one token in the cell row");

  // A token leaving the row is never met by a new injection.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    link[vic_pkg::MAX_VARS].active |-> !link[0].active)
    else $error("token injected while another one returns");

  // A full-table result only occurs once every slot is taken.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == vic_pkg::ST_FULL |-> cnt_sum == 9'(vic_pkg::MAX_VARS))
    else $error("table full reported with free entries");

  // An out-of-range reverse item is passed back as an algebraic reference.
  a_range_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == vic_pkg::ST_RANGE |-> out_kind == vic_pkg::KIND_ALG)
    else $error("range error on a non-algebraic item");
`endif

endmodule
